// File: hw/rtl/lsra_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the linear-scan register allocator.
// Used by lsra_cfg and linear_scan_register_allocator_core; depends on nothing.
package lsra_pkg;

    // Sizing
    localparam int VIRT_REGS    = 32;
    localparam int PHYS_REGS    = 8;
    localparam int MAX_POSITION = 1024;
    localparam int SLOTS        = 2 * PHYS_REGS;

    localparam int VIDX_W = $clog2(VIRT_REGS);
    localparam int CNT_W  = $clog2(VIRT_REGS + 1);
    localparam int POS_W  = $clog2(MAX_POSITION);
    localparam int PIDX_W = $clog2(PHYS_REGS);
    localparam int SLOT_W = $clog2(SLOTS);

    // Fixed word field widths
    localparam int VIRT_W = 5;
    localparam int PHYS_W = 3;
    localparam int MASK_W = 8;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int RIDX_W = 1;
    localparam logic [RIDX_W-1:0] REG_GP_MASK  = 1'b0;
    localparam logic [RIDX_W-1:0] REG_VEC_MASK = 1'b1;

    localparam logic [MASK_W-1:0] GP_MASK_RST  = 8'd17;
    localparam logic [MASK_W-1:0] VEC_MASK_RST = 8'd0;

    // Register classes
    localparam logic CLASS_GP  = 1'b0;
    localparam logic CLASS_VEC = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0] gp_mask;
        logic [MASK_W-1:0] vec_mask;
    } t_cfg;

    localparam t_cfg CFG_RST = '{gp_mask: GP_MASK_RST, vec_mask: VEC_MASK_RST};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ORD,
        S_ENT,
        S_FREE,
        S_ALLOC
    } t_state;

    // Reserved slots of both classes: GP in the low half, vector in the high half
    function automatic logic [SLOTS-1:0] res_all(input t_cfg cfg);
        logic [SLOTS-1:0] r;
        r = '0;
        for (int i = 0; i < PHYS_REGS; i++) begin
            if (i < MASK_W) begin
                r[i]             = cfg.gp_mask[i];
                r[PHYS_REGS + i] = cfg.vec_mask[i];
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/linear_scan_register_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the linear-scan register allocator: reference capture, allocation pass.
// Depends on lsra_pkg and lsra_cfg.

// References load at one word per cycle: each fills the interval table and, on a first
// use, appends the virtual register to the first-use order. The word flagged last starts
// the allocation pass, during which the input is stalled. For each recorded interval the
// pass reads the order memory, then reads the interval, then steps the single endpoint
// comparator over every physical slot of both classes to free expired registers, and
// last picks the lowest free register and emits the word, waiting while the output is
// stalled. The stores clear in the cycle the last result is produced, so the next
// block's first reference is taken right after. An exhausted class yields physical
// register 0 with no_free_register set.
module linear_scan_register_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // reference words
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_reg_class,
    input  logic [4:0]                   i_virt_index,
    input  logic [9:0]                   i_position,
    input  logic                         i_last,
    // assignment words
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [4:0]                   o_out_virt,
    output logic [2:0]                   o_phys_id,
    output logic                         o_no_free_register,
    output logic                         o_out_last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsra_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsra_pkg::DATA_W-1:0]  pwdata,
    output logic [lsra_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int VR = lsra_pkg::VIRT_REGS;
    localparam int PR = lsra_pkg::PHYS_REGS;
    localparam int SL = lsra_pkg::SLOTS;

    lsra_pkg::t_cfg                   w_cfg;
    logic [SL-1:0]                    w_res;

    // Control state
    lsra_pkg::t_state                 r_state, n_state;
    logic [VR-1:0]                    r_valid, n_valid;
    logic [lsra_pkg::CNT_W-1:0]       r_count, n_count;
    logic [lsra_pkg::CNT_W-1:0]       r_k, n_k;
    logic [lsra_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic [SL-1:0]                    r_busy, n_busy;

    // Stores
    logic [lsra_pkg::POS_W-1:0]       r_ep [SL];
    logic                             mem_cls   [VR];
    logic [lsra_pkg::POS_W-1:0]       mem_start [VR];
    logic [lsra_pkg::POS_W-1:0]       mem_end   [VR];
    logic [lsra_pkg::VIDX_W-1:0]      mem_ord   [VR];

    // Registered memory reads
    logic [lsra_pkg::VIDX_W-1:0]      r_ord_q;
    logic                             r_cls_q;
    logic [lsra_pkg::POS_W-1:0]       r_start_q;
    logic [lsra_pkg::POS_W-1:0]       r_end_q;

    // Output register
    logic                             r_out_valid, n_out_valid;
    logic [lsra_pkg::VIRT_W-1:0]      r_out_virt;
    logic [lsra_pkg::PHYS_W-1:0]      r_out_phys;
    logic                             r_out_nofree;
    logic                             r_out_last;

    // Load-side decode
    logic                             w_accept;
    logic [lsra_pkg::VIDX_W-1:0]      w_vidx;
    logic [lsra_pkg::POS_W-1:0]       w_pos;
    logic                             w_in_range;
    logic                             w_hit;
    logic                             w_open;
    logic                             w_upd;
    logic [lsra_pkg::CNT_W-1:0]       w_count_after;

    // Allocation datapath
    logic                             w_slot_free;
    logic [PR-1:0]                    w_cls_busy;
    logic                             w_found;
    logic [lsra_pkg::PIDX_W-1:0]      w_pick;
    logic [lsra_pkg::SLOT_W-1:0]      w_pick_slot;
    logic                             w_out_room;
    logic                             w_adv;
    logic                             w_final;
    logic [lsra_pkg::CNT_W-1:0]       w_k_inc;

    lsra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_res = lsra_pkg::res_all(w_cfg);

    // Decode the incoming reference
    assign o_stall       = (r_state != lsra_pkg::S_IDLE);
    assign w_accept      = i_valid && !o_stall;
    assign w_vidx        = lsra_pkg::VIDX_W'(i_virt_index);
    assign w_pos         = lsra_pkg::POS_W'(i_position);
    assign w_in_range    = ({1'b0, i_virt_index} < 6'(VR));
    assign w_hit         = r_valid[w_vidx];
    assign w_open        = w_accept && w_in_range && !w_hit
                           && (r_count < lsra_pkg::CNT_W'(VR));
    assign w_upd         = w_accept && w_in_range && w_hit;
    assign w_count_after = r_count + lsra_pkg::CNT_W'(w_open);

    // Shared endpoint comparator: one slot per cycle
    assign w_slot_free = r_busy[r_slot] && !w_res[r_slot] && (r_ep[r_slot] < r_start_q);

    // Lowest free register of the interval's class
    assign w_cls_busy = (r_cls_q == lsra_pkg::CLASS_VEC) ? r_busy[SL-1:PR] : r_busy[PR-1:0];

    always_comb begin
        w_found = 1'b0;
        w_pick  = '0;
        for (int p = PR - 1; p >= 0; p--) begin
            if (!w_cls_busy[p]) begin
                w_found = 1'b1;
                w_pick  = lsra_pkg::PIDX_W'(p);
            end
        end
    end

    assign w_pick_slot = (r_cls_q == lsra_pkg::CLASS_VEC)
                         ? lsra_pkg::SLOT_W'(PR) + lsra_pkg::SLOT_W'(w_pick)
                         : lsra_pkg::SLOT_W'(w_pick);

    assign w_out_room = !r_out_valid || !i_stall;
    assign w_adv      = (r_state == lsra_pkg::S_ALLOC) && w_out_room;
    assign w_k_inc    = r_k + lsra_pkg::CNT_W'(1);
    assign w_final    = (w_k_inc == r_count);

    // Sequencer: next state and control updates
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_k         = r_k;
        n_slot      = r_slot;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            lsra_pkg::S_IDLE: begin
                if (w_open) begin
                    n_valid[w_vidx] = 1'b1;
                end
                n_count = w_count_after;
                if (w_accept && i_last) begin
                    n_busy = w_res;
                    n_k    = '0;
                    if (w_count_after != '0) begin
                        n_state = lsra_pkg::S_ORD;
                    end
                end
            end
            lsra_pkg::S_ORD: begin
                n_state = lsra_pkg::S_ENT;
            end
            lsra_pkg::S_ENT: begin
                n_slot  = '0;
                n_state = lsra_pkg::S_FREE;
            end
            lsra_pkg::S_FREE: begin
                if (w_slot_free) begin
                    n_busy[r_slot] = 1'b0;
                end
                if (r_slot == lsra_pkg::SLOT_W'(SL - 1)) begin
                    n_state = lsra_pkg::S_ALLOC;
                end else begin
                    n_slot = r_slot + lsra_pkg::SLOT_W'(1);
                end
            end
            lsra_pkg::S_ALLOC: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_k         = w_k_inc;
                    if (w_found) begin
                        n_busy[w_pick_slot] = 1'b1;
                    end
                    if (w_final) begin
                        // drop the block's stores
                        n_valid = '0;
                        n_count = '0;
                        n_busy  = w_res;
                        n_state = lsra_pkg::S_IDLE;
                    end else begin
                        n_state = lsra_pkg::S_ORD;
                    end
                end
            end
            default: begin
                n_state = lsra_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_slot      <= '0;
            r_busy      <= lsra_pkg::res_all(lsra_pkg::CFG_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_k         <= n_k;
            r_slot      <= n_slot;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Interval and order stores
    always_ff @(posedge i_clk) begin
        if (w_open || w_upd) begin
            mem_end[w_vidx] <= w_pos;
        end
        if (w_open) begin
            mem_cls[w_vidx]                           <= i_reg_class;
            mem_start[w_vidx]                         <= w_pos;
            mem_ord[r_count[lsra_pkg::VIDX_W-1:0]]    <= w_vidx;
        end
        r_ord_q   <= mem_ord[r_k[lsra_pkg::VIDX_W-1:0]];
        r_cls_q   <= mem_cls[r_ord_q];
        r_start_q <= mem_start[r_ord_q];
        r_end_q   <= mem_end[r_ord_q];
    end

    // Record the endpoint of a newly taken register
    always_ff @(posedge i_clk) begin
        if (w_adv && w_found) begin
            r_ep[w_pick_slot] <= r_end_q;
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_virt   <= lsra_pkg::VIRT_W'(r_ord_q);
            r_out_phys   <= w_found ? lsra_pkg::PHYS_W'(w_pick) : '0;
            r_out_nofree <= !w_found;
            r_out_last   <= w_final;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_virt         = r_out_virt;
    assign o_phys_id          = r_out_phys;
    assign o_no_free_register = r_out_nofree;
    assign o_out_last         = r_out_last;

`ifndef ASSERT_OFF
    // The interval count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lsra_pkg::CNT_W'(VR))
        else $error("interval count above table depth");

    // Reserved registers stay busy throughout the pass
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lsra_pkg::S_IDLE) |-> ((r_busy & w_res) == w_res))
        else $error("reserved register freed or handed out");

    // The pass index stays below the interval count
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lsra_pkg::S_IDLE) |-> (r_k < r_count))
        else $error("pass index past interval count");

    // The final assignment clears the block's stores
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_final) |=> (r_count == '0 && r_valid == '0
                                && r_state == lsra_pkg::S_IDLE && o_out_last))
        else $error("stores not cleared after last assignment");
`endif

endmodule

// File: hw/rtl/lsra_cfg.sv
`timescale 1ns / 1ps
// APB-style register file holding the reserved-register masks.
// Depends on lsra_pkg.
module lsra_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsra_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsra_pkg::DATA_W-1:0]  pwdata,
    output logic [lsra_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output lsra_pkg::t_cfg               o_cfg
);

    lsra_pkg::t_cfg                  r_cfg;
    logic [lsra_pkg::RIDX_W-1:0]     w_idx;
    logic                            w_wr;

    assign w_idx  = paddr[lsra_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed mask in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lsra_pkg::CFG_RST;
        end else if (w_wr) begin
            case (w_idx)
                lsra_pkg::REG_GP_MASK:  r_cfg.gp_mask  <= pwdata[lsra_pkg::MASK_W-1:0];
                lsra_pkg::REG_VEC_MASK: r_cfg.vec_mask <= pwdata[lsra_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended
    always_comb begin
        case (w_idx)
            lsra_pkg::REG_GP_MASK:  prdata = lsra_pkg::DATA_W'(r_cfg.gp_mask);
            lsra_pkg::REG_VEC_MASK: prdata = lsra_pkg::DATA_W'(r_cfg.vec_mask);
            default:                prdata = '0;
        endcase
    end

endmodule
